// File: src/pfa_pkg.sv
// Package for the paged frame allocator: transfer payload types, request and
// status codes, register map and the command/status structs between the
// controller and the datapath. Depends on nothing.
package pfa_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_DEALLOC  = 2'd1;
    localparam logic [1:0] KIND_PAGE_IN  = 2'd2;
    localparam logic [1:0] KIND_PAGE_OUT = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FRAME  = 3'd1;
    localparam logic [2:0] ST_TOO_MANY  = 3'd2;
    localparam logic [2:0] ST_NO_PROC   = 3'd3;
    localparam logic [2:0] ST_PAGE_OOR  = 3'd4;

    // Register map and reset values.
    localparam logic REG_FRAME_BYTES   = 1'b0;
    localparam logic REG_FRAMES_IN_USE = 1'b1;
    localparam logic [16:0] FRAME_BYTES_RST   = 17'd16;
    localparam logic [6:0]  FRAMES_IN_USE_RST = 7'd64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  process_slot;
        logic [20:0] request_bytes;
        logic [3:0]  page_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  mapped_frame;
        logic [4:0]  pages_held;
        logic [6:0]  frames_used;
        logic [31:0] paged_in_total;
        logic [31:0] paged_out_total;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       clr_scan;
        logic       div_step;
        logic       cntf_step;
        logic       cnto_step;
        logic       drop_step;
        logic       drop_end;
        logic       claim_step;
        logic       claim_end;
        logic       use_page;
        logic       pg_use;
        logic       pin_step;
        logic       finish;
        logic [2:0] code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       slot_bad;
        logic       present;
        logic       page_bad;
        logic       rem_zero;
        logic       too_many;
        logic       f_end;
        logic       f_free;
        logic       i_end;
        logic       claim_done;
        logic       short_frames;
        logic       ent_valid;
    } t_sts;

endpackage

// File: src/pfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pfa_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/pfa_ctrl.sv
// Controller state machine of the paged frame allocator. It sequences the
// datapath through commands and reads its status. Depends on pfa_pkg.
module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pfa_pkg::t_sts i_sts,
    output pfa_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_CNTF     = 4'd3;
    localparam logic [3:0] S_CNTO_RD  = 4'd4;
    localparam logic [3:0] S_CNTO_USE = 4'd5;
    localparam logic [3:0] S_CHK      = 4'd6;
    localparam logic [3:0] S_DROP_RD  = 4'd7;
    localparam logic [3:0] S_DROP_USE = 4'd8;
    localparam logic [3:0] S_CLAIM    = 4'd9;
    localparam logic [3:0] S_PG_RD    = 4'd10;
    localparam logic [3:0] S_PG_USE   = 4'd11;
    localparam logic [3:0] S_PIN_SCAN = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0] r_state, n_state;
    logic [2:0] r_code, n_code;
    pfa_pkg::t_cmd cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_code   = pfa_pkg::ST_OK;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.slot_bad) begin
                    n_code  = pfa_pkg::ST_NO_PROC;
                    n_state = S_DONE;
                end else if (i_sts.kind == pfa_pkg::KIND_ALLOC) begin
                    n_state = S_DIV;
                end else if (!i_sts.present) begin
                    n_code  = pfa_pkg::ST_NO_PROC;
                    n_state = S_DONE;
                end else if (i_sts.kind == pfa_pkg::KIND_DEALLOC) begin
                    n_state = S_DROP_RD;
                end else if (i_sts.page_bad) begin
                    n_code  = pfa_pkg::ST_PAGE_OOR;
                    n_state = S_DONE;
                end else begin
                    cmd.use_page = 1'b1;
                    n_state      = S_PG_RD;
                end
            end
            S_DIV: begin
                if (i_sts.too_many) begin
                    n_code  = pfa_pkg::ST_TOO_MANY;
                    n_state = S_DONE;
                end else if (i_sts.rem_zero) begin
                    n_state = S_CNTF;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_CNTF: begin
                if (i_sts.f_end) begin
                    n_state = i_sts.present ? S_CNTO_RD : S_CHK;
                end else begin
                    cmd.cntf_step = 1'b1;
                end
            end
            S_CNTO_RD: begin
                n_state = i_sts.i_end ? S_CHK : S_CNTO_USE;
            end
            S_CNTO_USE: begin
                cmd.cnto_step = 1'b1;
                n_state       = S_CNTO_RD;
            end
            S_CHK: begin
                if (i_sts.short_frames) begin
                    n_code  = pfa_pkg::ST_NO_FRAME;
                    n_state = S_DONE;
                end else begin
                    cmd.clr_scan = 1'b1;
                    n_state      = S_DROP_RD;
                end
            end
            S_DROP_RD: begin
                if (i_sts.i_end) begin
                    cmd.drop_end = 1'b1;
                    cmd.clr_scan = 1'b1;
                    n_state      = (i_sts.kind == pfa_pkg::KIND_ALLOC) ? S_CLAIM : S_DONE;
                end else begin
                    n_state = S_DROP_USE;
                end
            end
            S_DROP_USE: begin
                cmd.drop_step = 1'b1;
                n_state       = S_DROP_RD;
            end
            S_CLAIM: begin
                if (i_sts.claim_done) begin
                    cmd.claim_end = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    cmd.claim_step = 1'b1;
                end
            end
            S_PG_RD: begin
                cmd.use_page = 1'b1;
                n_state      = S_PG_USE;
            end
            S_PG_USE: begin
                cmd.use_page = 1'b1;
                cmd.pg_use   = 1'b1;
                if (i_sts.kind == pfa_pkg::KIND_PAGE_IN && !i_sts.ent_valid) begin
                    n_state = S_PIN_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PIN_SCAN: begin
                cmd.use_page = 1'b1;
                cmd.pin_step = 1'b1;
                if (i_sts.f_end) begin
                    n_code  = pfa_pkg::ST_NO_FRAME;
                    n_state = S_DONE;
                end else if (i_sts.f_free) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                cmd.code   = r_code;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= pfa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
endmodule

// File: src/pfa_dp.sv
// Datapath of the paged frame allocator: frame bitmap, page table memory,
// table lengths, counters and the result register. Depends on pfa_pkg, pfa_ram.
module pfa_dp #(
    parameter int FRAMES    = 64,
    parameter int PROCESSES = 16,
    parameter int MAX_PAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [16:0]   i_frame_bytes,
    input  logic [6:0]    i_frames_in_use,
    input  pfa_pkg::t_req i_req,
    input  pfa_pkg::t_cmd i_cmd,
    output pfa_pkg::t_sts o_sts,
    output pfa_pkg::t_rsp o_rsp,
    output logic          o_rsp_valid
);
    localparam int FW    = $clog2(FRAMES);
    localparam int CW    = $clog2(FRAMES + 1);
    localparam int PW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int LW    = $clog2(MAX_PAGES + 1);
    localparam int PGW   = $clog2(MAX_PAGES + 2);
    localparam int DEPTH = PROCESSES * MAX_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = FW + 1;
    localparam int LMW   = (CW > 7) ? CW : 7;

    // Request registers.
    logic [1:0]     r_kind;
    logic [3:0]     r_slot;
    logic [3:0]     r_page;
    logic [20:0]    r_rem;
    logic [PGW-1:0] r_pages;
    logic [CW-1:0]  r_avail;
    logic [CW-1:0]  r_f;
    logic [LW-1:0]  r_i;
    logic [FW-1:0]  r_mapped;
    pfa_pkg::t_rsp  r_rsp;

    // Allocator state.
    logic [FRAMES-1:0]    r_busy;
    logic [CW-1:0]        r_busy_cnt;
    logic [LW-1:0]        r_len [PROCESSES];
    logic [PROCESSES-1:0] r_present;
    logic [31:0]          r_in_cnt;
    logic [31:0]          r_out_cnt;
    logic                 r_valid;

    logic [PW-1:0]  slot_idx;
    logic           slot_bad;
    logic [LW-1:0]  cur_len;
    logic [16:0]    fb;
    logic [LMW-1:0] fiu_x;
    logic [CW-1:0]  lim;
    logic [FW-1:0]  f_idx;
    logic           f_free;
    logic           f_end;
    logic [AW-1:0]  addr;
    logic [EW-1:0]  ram_q;
    logic           ent_valid;
    logic [FW-1:0]  ent_frame;
    logic           take_claim;
    logic           take_pin;
    logic           take_out;
    logic           take_drop;
    logic           rel_en;
    logic           ram_we;
    logic [EW-1:0]  ram_wdata;

    // Decode of the held request and of the configuration.
    assign slot_idx  = PW'(r_slot);
    assign slot_bad  = (32'(r_slot) >= PROCESSES);
    assign cur_len   = r_len[slot_idx];
    assign fb        = (i_frame_bytes == 17'd0) ? 17'd1 : i_frame_bytes;
    assign fiu_x     = LMW'(i_frames_in_use);
    assign lim       = (fiu_x > LMW'(FRAMES)) ? CW'(FRAMES) : CW'(fiu_x);
    assign f_idx     = r_f[FW-1:0];
    assign f_end     = (r_f >= lim);
    assign f_free    = !r_busy[f_idx];
    assign addr      = AW'(slot_idx) * AW'(MAX_PAGES)
                     + (i_cmd.use_page ? AW'(r_page) : AW'(r_i));
    assign ent_valid = ram_q[FW];
    assign ent_frame = ram_q[FW-1:0];

    // Actions that depend on the data seen in this cycle.
    assign take_claim = i_cmd.claim_step && f_free;
    assign take_pin   = i_cmd.pin_step && !f_end && f_free;
    assign take_out   = i_cmd.pg_use && (r_kind == pfa_pkg::KIND_PAGE_OUT) && ent_valid;
    assign take_drop  = i_cmd.drop_step && ent_valid;
    assign rel_en     = (take_out || take_drop) && r_busy[ent_frame];
    assign ram_we     = take_claim || take_pin || take_out;
    assign ram_wdata  = take_out ? {1'b0, ent_frame} : {1'b1, f_idx};

    pfa_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (ram_wdata),
        .i_raddr (addr),
        .o_rdata (ram_q)
    );

    // Control state: bitmap, lengths, counters and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= '0;
            r_busy_cnt <= '0;
            r_present  <= '0;
            r_in_cnt   <= '0;
            r_out_cnt  <= '0;
            r_valid    <= 1'b0;
            for (int k = 0; k < PROCESSES; k++) begin
                r_len[k] <= '0;
            end
        end else begin
            r_valid <= i_cmd.finish;
            if (take_claim || take_pin) begin
                r_busy[f_idx] <= 1'b1;
                r_busy_cnt    <= r_busy_cnt + CW'(1);
            end else if (rel_en) begin
                r_busy[ent_frame] <= 1'b0;
                r_busy_cnt        <= r_busy_cnt - CW'(1);
            end
            if (take_pin) begin
                r_in_cnt <= r_in_cnt + 32'd1;
            end
            if (take_out) begin
                r_out_cnt <= r_out_cnt + 32'd1;
            end
            if (i_cmd.drop_end) begin
                r_len[slot_idx]     <= '0;
                r_present[slot_idx] <= 1'b0;
            end else if (i_cmd.claim_end) begin
                r_len[slot_idx]     <= LW'(r_pages);
                r_present[slot_idx] <= 1'b1;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_req.kind;
            r_slot   <= i_req.process_slot;
            r_page   <= i_req.page_index;
            r_rem    <= i_req.request_bytes;
            r_pages  <= '0;
            r_avail  <= '0;
            r_f      <= '0;
            r_i      <= '0;
            r_mapped <= '0;
        end else begin
            // Page count by repeated subtraction of the frame size.
            if (i_cmd.div_step) begin
                r_pages <= r_pages + PGW'(1);
                r_rem   <= (r_rem <= 21'(fb)) ? 21'd0 : r_rem - 21'(fb);
            end
            // Free frames below the limit, then frames the process gives back.
            if ((i_cmd.cntf_step && f_free)
                || (i_cmd.cnto_step && ent_valid && (CW'(ent_frame) < lim))) begin
                r_avail <= r_avail + CW'(1);
            end
            if (i_cmd.clr_scan) begin
                r_f <= '0;
                r_i <= '0;
            end else begin
                if (i_cmd.cntf_step || i_cmd.claim_step
                    || (i_cmd.pin_step && !f_free)) begin
                    r_f <= r_f + CW'(1);
                end
                if (i_cmd.cnto_step || i_cmd.drop_step || take_claim) begin
                    r_i <= r_i + LW'(1);
                end
            end
            if (i_cmd.pg_use && (r_kind == pfa_pkg::KIND_PAGE_IN) && ent_valid) begin
                r_mapped <= ent_frame;
            end else if (take_pin) begin
                r_mapped <= f_idx;
            end
        end
        // Result register.
        if (i_cmd.finish) begin
            r_rsp.status          <= i_cmd.code;
            r_rsp.mapped_frame    <= 6'(r_mapped);
            r_rsp.pages_held      <= slot_bad ? 5'd0 : 5'(cur_len);
            r_rsp.frames_used     <= 7'(r_busy_cnt);
            r_rsp.paged_in_total  <= r_in_cnt;
            r_rsp.paged_out_total <= r_out_cnt;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts              = '0;
        o_sts.kind         = r_kind;
        o_sts.slot_bad     = slot_bad;
        o_sts.present      = r_present[slot_idx];
        o_sts.page_bad     = (32'(r_page) >= 32'(cur_len)) || (32'(r_page) >= MAX_PAGES);
        o_sts.rem_zero     = (r_rem == 21'd0);
        o_sts.too_many     = (32'(r_pages) > MAX_PAGES);
        o_sts.f_end        = f_end;
        o_sts.f_free       = f_free;
        o_sts.i_end        = (r_i >= cur_len);
        o_sts.claim_done   = (PGW'(r_i) == r_pages);
        o_sts.short_frames = (32'(r_avail) < 32'(r_pages));
        o_sts.ent_valid    = ent_valid;
    end

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_valid;
endmodule

// File: src/paged_frame_allocator_unit.sv
// Top level of the paged frame allocator: APB register file, controller and
// datapath. Depends on pfa_pkg, pfa_ctrl, pfa_dp.
//
// One request is taken when start is high and busy is low. Its single result
// appears for one cycle on o_rsp with o_result_valid, in the first cycle in
// which busy is low again, and cannot be held off. Time is set by the
// one-frame-per-cycle scan of the frame bitmap, the repeated subtraction that
// counts pages and the walk of the page table memory, with a read state and a
// use state per entry. An allocation counts its pages, scans the frames below
// the limit for free ones and, for a present process, walks its old table to
// count the frames it gives back; it then frees that table and claims its
// frames. An allocation refused for lack of frames stops before freeing, and
// one asking for too many pages stops while counting them. Page in scans the
// frames below the limit for a free one only when the page is not mapped.
// Page out reads one entry, deallocate walks the table, and an absent
// process or a page out of range ends after decode. No clearing pass runs
// after reset: table entries beyond a process's length are never read.
module paged_frame_allocator_unit #(
    parameter int FRAMES    = 64,
    parameter int PROCESSES = 16,
    parameter int MAX_PAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          start,
    output logic          busy,
    input  pfa_pkg::t_req i_req,
    output pfa_pkg::t_rsp o_rsp,
    output logic          o_result_valid
);
    logic [16:0]   r_frame_bytes;
    logic [6:0]    r_frames_in_use;
    pfa_pkg::t_cmd cmd;
    pfa_pkg::t_sts sts;
    logic          ctrl_busy;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes   <= pfa_pkg::FRAME_BYTES_RST;
            r_frames_in_use <= pfa_pkg::FRAMES_IN_USE_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == pfa_pkg::REG_FRAME_BYTES) begin
                r_frame_bytes <= pwdata[16:0];
            end else begin
                r_frames_in_use <= pwdata[6:0];
            end
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == pfa_pkg::REG_FRAMES_IN_USE) ? 32'(r_frames_in_use)
                                                             : 32'(r_frame_bytes);
    assign pready = 1'b1;

    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    pfa_dp #(
        .FRAMES    (FRAMES),
        .PROCESSES (PROCESSES),
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_bytes   (r_frame_bytes),
        .i_frames_in_use (r_frames_in_use),
        .i_req           (i_req),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_rsp           (o_rsp),
        .o_rsp_valid     (o_result_valid)
    );

    assign busy = ctrl_busy;
endmodule

// File: src/pfa_checker.sv
// Port-level checks for the paged frame allocator, bound to the top level.
// Depends on pfa_pkg and paged_frame_allocator_unit.
module pfa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input pfa_pkg::t_rsp o_rsp,
    input logic          o_result_valid
);
    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted request");

    // Each result transfer lasts a single cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_rsp.status <= pfa_pkg::ST_PAGE_OOR))
        else $error("undefined status code");

    // A failed request never reports a mapped frame.
    a_fail_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_rsp.status != pfa_pkg::ST_OK)) |-> (o_rsp.mapped_frame == 6'd0))
        else $error("mapped frame reported with a failing status");
endmodule

bind paged_frame_allocator_unit pfa_checker u_pfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_rsp          (o_rsp),
    .o_result_valid (o_result_valid)
);

// File: verif/pfa_checker.sv
`timescale 1ns / 1ps
// Checker for the paged frame allocator: watches request and result transfers,
// keeps its own copy of the frame bitmap and page tables and compares results.
// Depends on pfa_pkg.
module pfa_tb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  pfa_pkg::t_req i_req,
    input  pfa_pkg::t_rsp i_rsp,
    input  logic          i_result_valid,
    input  logic [16:0]   i_frame_bytes,
    input  logic [6:0]    i_frames_limit,
    output int            o_fail_count,
    output int            o_pending
);
    localparam int NFR = 64;
    localparam int NPROC = 16;
    localparam int NPG = 16;

    bit            frame_taken [NFR];
    bit            entry_valid [NPROC][NPG];
    logic [5:0]    entry_frame [NPROC][NPG];
    int unsigned   held_len    [NPROC];
    bit            proc_live   [NPROC];
    int unsigned   taken_total;
    logic [31:0]   ins_total;
    logic [31:0]   outs_total;
    pfa_pkg::t_rsp awaited_rsp [16];
    logic [3:0]    wr_ptr;
    logic [3:0]    rd_ptr;
    int            queued;
    int            fails;

    assign o_fail_count = fails;
    assign o_pending    = queued;

    function automatic int unsigned frame_cap();
        return (i_frames_limit > NFR) ? NFR : i_frames_limit;
    endfunction

    function automatic int unsigned first_free();
        for (int f = 0; f < frame_cap(); f++)
            if (!frame_taken[f]) return f;
        return NFR;
    endfunction

    function automatic void free_frame(int unsigned f);
        if (f < NFR && frame_taken[f]) begin
            frame_taken[f] = 0;
            taken_total--;
        end
    endfunction

    function automatic void take_frame(int unsigned f);
        if (f < NFR && !frame_taken[f]) begin
            frame_taken[f] = 1;
            taken_total++;
        end
    endfunction

    function automatic void release_process(int unsigned p);
        for (int i = 0; i < held_len[p] && i < NPG; i++) begin
            if (entry_valid[p][i]) free_frame(entry_frame[p][i]);
            entry_valid[p][i] = 0;
            entry_frame[p][i] = '0;
        end
        held_len[p] = 0;
        proc_live[p] = 0;
    endfunction

    function automatic logic [2:0] allocate_pages(int unsigned p, longint unsigned nbytes);
        longint unsigned unit, pages;
        int unsigned spare, f;
        unit = (i_frame_bytes == 0) ? 1 : i_frame_bytes;
        pages = (nbytes + unit - 1) / unit;
        spare = 0;
        if (pages > NPG) return pfa_pkg::ST_TOO_MANY;
        for (int k = 0; k < frame_cap(); k++)
            if (!frame_taken[k]) spare++;
        if (proc_live[p])
            for (int i = 0; i < held_len[p] && i < NPG; i++)
                if (entry_valid[p][i] && entry_frame[p][i] < frame_cap()) spare++;
        if (spare < pages) return pfa_pkg::ST_NO_FRAME;
        release_process(p);
        for (int i = 0; i < pages; i++) begin
            f = first_free();
            take_frame(f);
            entry_valid[p][i] = 1;
            entry_frame[p][i] = f[5:0];
        end
        held_len[p] = 32'(pages);
        proc_live[p] = 1;
        return pfa_pkg::ST_OK;
    endfunction

    // Work out the result of one accepted request and update the state.
    function automatic pfa_pkg::t_rsp serve_request(pfa_pkg::t_req rq);
        pfa_pkg::t_rsp r;
        int unsigned p, pg, f;
        p = rq.process_slot;
        pg = rq.page_index;
        r = '0;
        if (rq.kind == pfa_pkg::KIND_ALLOC) begin
            r.status = allocate_pages(p, rq.request_bytes);
        end else if (!proc_live[p]) begin
            r.status = pfa_pkg::ST_NO_PROC;
        end else if (rq.kind == pfa_pkg::KIND_DEALLOC) begin
            release_process(p);
        end else if (pg >= held_len[p]) begin
            r.status = pfa_pkg::ST_PAGE_OOR;
        end else if (rq.kind == pfa_pkg::KIND_PAGE_IN) begin
            if (entry_valid[p][pg]) begin
                r.mapped_frame = entry_frame[p][pg];
            end else begin
                f = first_free();
                if (f >= NFR) begin
                    r.status = pfa_pkg::ST_NO_FRAME;
                end else begin
                    take_frame(f);
                    entry_valid[p][pg] = 1;
                    entry_frame[p][pg] = f[5:0];
                    r.mapped_frame = f[5:0];
                    ins_total++;
                end
            end
        end else begin
            if (entry_valid[p][pg]) begin
                free_frame(entry_frame[p][pg]);
                entry_valid[p][pg] = 0;
                outs_total++;
            end
        end
        r.pages_held = held_len[p][4:0];
        r.frames_used = taken_total[6:0];
        r.paged_in_total = ins_total;
        r.paged_out_total = outs_total;
        return r;
    endfunction

    // Predict on each request transfer and compare each result transfer.
    always @(posedge i_clk) begin
        pfa_pkg::t_rsp want;
        if (!i_rst_n) begin
            for (int p = 0; p < NPROC; p++) begin
                held_len[p] = 0;
                proc_live[p] = 0;
                for (int i = 0; i < NPG; i++) begin
                    entry_valid[p][i] = 0;
                    entry_frame[p][i] = '0;
                end
            end
            for (int f = 0; f < NFR; f++) frame_taken[f] = 0;
            taken_total = 0;
            ins_total = '0;
            outs_total = '0;
            fails = 0;
            wr_ptr = '0;
            rd_ptr = '0;
            queued = 0;
        end else begin
            if (i_result_valid) begin
                if (queued == 0) begin
                    fails++;
                    if (fails <= 10) $display("Result with no request waiting: %p", i_rsp);
                end else begin
                    want = awaited_rsp[rd_ptr];
                    rd_ptr = rd_ptr + 4'd1;
                    queued--;
                    if (i_rsp !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("Mismatch: expected %p, got %p", want, i_rsp);
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_rsp[wr_ptr] = serve_request(i_req);
                wr_ptr = wr_ptr + 4'd1;
                queued++;
            end
        end
    end
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top of the paged frame allocator testbench: clock, reset, register writes
// and request stimulus. Depends on pfa_pkg, paged_frame_allocator_unit, pfa_tb_checker.
module tb;
    logic          i_clk, i_rst_n;
    logic          psel, penable, pwrite, pready;
    logic [2:0]    paddr;
    logic [31:0]   pwdata, prdata;
    logic          start, busy, o_result_valid;
    pfa_pkg::t_req i_req;
    pfa_pkg::t_rsp o_rsp;
    logic [16:0]   frame_bytes_set;
    logic [6:0]    frames_limit_set;
    int            fail_count, pending;
    int            idle_cycles;

    paged_frame_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .start(start), .busy(busy), .i_req(i_req),
        .o_rsp(o_rsp), .o_result_valid(o_result_valid)
    );

    pfa_tb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_req(i_req), .i_rsp(o_rsp), .i_result_valid(o_result_valid),
        .i_frame_bytes(frame_bytes_set), .i_frames_limit(frames_limit_set),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on cycles with no transfer at all.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL paged_frame_allocator_unit");
            $finish;
        end
    end

    // Register write: setup cycle then access cycle.
    task automatic write_register(logic idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == pfa_pkg::REG_FRAME_BYTES) frame_bytes_set <= value[16:0];
        else frames_limit_set <= value[6:0];
    endtask

    // Present one request and hold it until it is taken.
    task automatic issue_request(logic [1:0] k, logic [3:0] p, logic [20:0] b, logic [3:0] pg);
        start <= 1;
        i_req <= '{kind: k, process_slot: p, request_bytes: b, page_index: pg};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(int n);
        start <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // Random request, mostly well formed and sized to fit the frame size.
    task automatic random_request();
        logic [1:0]  k;
        logic [20:0] b;
        int unsigned fb;
        k = 2'($urandom_range(3, 0));
        fb = (frame_bytes_set == 0) ? 1 : frame_bytes_set;
        case ($urandom_range(9, 0))
            0: b = 21'($urandom);
            1: b = 21'h1FFFFF;
            default: b = 21'(fb * $urandom_range(4, 0) - $urandom_range(1, 0));
        endcase
        issue_request(k, 4'($urandom), b,
                      ($urandom_range(5, 0) == 0) ? 4'($urandom) : 4'($urandom_range(5, 0)));
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(12, 1);
            for (int i = 0; i < burst && n > 0; i++, n--) random_request();
            if ($urandom_range(2, 0) != 0) pause_sender($urandom_range(30, 1));
        end
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        start = 0; i_req = '0; idle_cycles = 0;
        frame_bytes_set = pfa_pkg::FRAME_BYTES_RST;
        frames_limit_set = pfa_pkg::FRAMES_IN_USE_RST;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        write_register(pfa_pkg::REG_FRAME_BYTES, 32'd16);
        write_register(pfa_pkg::REG_FRAMES_IN_USE, 32'd64);

        // Directed: absent process, zero bytes, extremes, page faults and repairs.
        issue_request(pfa_pkg::KIND_DEALLOC, 4'd3, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_PAGE_IN, 4'd3, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd0, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_PAGE_IN, 4'd0, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd1, 21'd256, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd2, 21'd257, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd15, 21'h1FFFFF, 4'd15);
        issue_request(pfa_pkg::KIND_PAGE_OUT, 4'd1, 21'd0, 4'd15);
        issue_request(pfa_pkg::KIND_PAGE_OUT, 4'd1, 21'd0, 4'd15);
        issue_request(pfa_pkg::KIND_PAGE_IN, 4'd1, 21'd0, 4'd15);
        issue_request(pfa_pkg::KIND_PAGE_IN, 4'd1, 21'd0, 4'd15);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd2, 21'd256, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd3, 21'd256, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd4, 21'd256, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd5, 21'd16, 4'd0);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd1, 21'd200, 4'd0);
        issue_request(pfa_pkg::KIND_PAGE_OUT, 4'd1, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_PAGE_IN, 4'd1, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_PAGE_IN, 4'd5, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_DEALLOC, 4'd1, 21'd0, 4'd0);
        issue_request(pfa_pkg::KIND_PAGE_OUT, 4'd15, 21'd0, 4'd0);
        wait_drained();

        // Random phases through several register settings, extremes included.
        random_phase(150);
        wait_drained();
        write_register(pfa_pkg::REG_FRAME_BYTES, 32'd0);
        write_register(pfa_pkg::REG_FRAMES_IN_USE, 32'd8);
        random_phase(120);
        wait_drained();
        write_register(pfa_pkg::REG_FRAME_BYTES, 32'h1FFFF);
        write_register(pfa_pkg::REG_FRAMES_IN_USE, 32'h7F);
        issue_request(pfa_pkg::KIND_ALLOC, 4'd6, 21'h1FFFFF, 4'd0);
        random_phase(100);
        wait_drained();
        write_register(pfa_pkg::REG_FRAME_BYTES, 32'd65536);
        write_register(pfa_pkg::REG_FRAMES_IN_USE, 32'd0);
        random_phase(60);
        wait_drained();
        write_register(pfa_pkg::REG_FRAME_BYTES, 32'd1);
        write_register(pfa_pkg::REG_FRAMES_IN_USE, 32'd1);
        random_phase(80);
        wait_drained();
        write_register(pfa_pkg::REG_FRAME_BYTES, 32'd64);
        write_register(pfa_pkg::REG_FRAMES_IN_USE, 32'd40);
        random_phase(220);
        wait_drained();

        if (fail_count == 0) $display("PASS paged_frame_allocator_unit");
        else $display("FAIL paged_frame_allocator_unit");
        $finish;
    end
endmodule
